### src/wsd_pkg.sv
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int LABEL_BITS_DEF = 64;

  localparam int NUM_W     = 32;
  localparam int LBL_OUT_W = 64;
  localparam int LEN_OUT_W = 7;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [4:0] {
    OP_PUSH  = 5'd0,
    OP_DUP   = 5'd1,
    OP_SWAP  = 5'd2,
    OP_DROP  = 5'd3,
    OP_ADD   = 5'd4,
    OP_SUB   = 5'd5,
    OP_MUL   = 5'd6,
    OP_DIV   = 5'd7,
    OP_MOD   = 5'd8,
    OP_STORE = 5'd9,
    OP_LOAD  = 5'd10,
    OP_LABEL = 5'd11,
    OP_CALL  = 5'd12,
    OP_JUMP  = 5'd13,
    OP_JZ    = 5'd14,
    OP_JNEG  = 5'd15,
    OP_RET   = 5'd16,
    OP_END   = 5'd17,
    OP_PUTC  = 5'd18,
    OP_PUTN  = 5'd19,
    OP_GETC  = 5'd20,
    OP_GETN  = 5'd21,
    OP_ERROR = 5'd22
  } op_t;

  // position in the prefix tree
  typedef enum logic [4:0] {
    POS_START    = 5'd0,
    POS_S        = 5'd1,
    POS_SL       = 5'd2,
    POS_T        = 5'd3,
    POS_TT       = 5'd4,
    POS_TS       = 5'd5,
    POS_TSS      = 5'd6,
    POS_TST      = 5'd7,
    POS_TL       = 5'd8,
    POS_TLS      = 5'd9,
    POS_TLT      = 5'd10,
    POS_L        = 5'd11,
    POS_LS       = 5'd12,
    POS_LT       = 5'd13,
    POS_LL       = 5'd14,
    POS_NUM_SIGN = 5'd15,
    POS_NUM_BITS = 5'd16,
    POS_LAB_MARK = 5'd17,
    POS_LAB_CALL = 5'd18,
    POS_LAB_JUMP = 5'd19,
    POS_LAB_JZ   = 5'd20,
    POS_LAB_JNEG = 5'd21
  } pos_t;

  typedef enum logic [1:0] {
    SYM_S = 2'd0,
    SYM_T = 2'd1,
    SYM_L = 2'd2,
    SYM_X = 2'd3
  } sym_t;

  typedef enum logic [1:0] {
    ACT_IDLE = 2'd0,
    ACT_GO   = 2'd1,
    ACT_EMIT = 2'd2,
    ACT_FAIL = 2'd3
  } act_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } item_t;

  typedef struct packed {
    op_t                   opcode;
    logic signed [NUM_W-1:0] number;
    logic [LBL_OUT_W-1:0]  label_bits;
    logic [LEN_OUT_W-1:0]  label_length;
    logic                  label_overflow;
  } res_t;

endpackage

### src/wsd_if.sv
`timescale 1ns / 1ps

interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_input;

  modport source (output valid, output char_byte, output end_of_input, input ready);
  modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface wsd_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         opcode;
  logic signed [31:0] number;
  logic [63:0]        label_bits;
  logic [6:0]         label_length;
  logic               label_overflow;

  modport source (output valid, output opcode, output number, output label_bits,
                  output label_length, output label_overflow, input ready);
  modport sink   (input valid, input opcode, input number, input label_bits,
                  input label_length, input label_overflow, output ready);
endinterface

### src/wsd_in_reg.sv
`timescale 1ns / 1ps

module wsd_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  wsd_in_if.sink        in_ch,
  input  logic          advance,
  output logic          item_valid,
  output wsd_pkg::item_t item
);
  import wsd_pkg::*;

  logic  valid_r;
  item_t item_r;
  logic  take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.char_byte    <= in_ch.char_byte;
      item_r.end_of_input <= in_ch.end_of_input;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### src/wsd_parser.sv
`timescale 1ns / 1ps

module wsd_parser #(
  parameter int LABEL_BITS = wsd_pkg::LABEL_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  wsd_pkg::item_t item,
  output logic           has_result,
  output wsd_pkg::res_t  result
);
  import wsd_pkg::*;

  localparam int CNT_W = $clog2(LABEL_BITS + 1);

  pos_t                  pos_r, pos_nxt;
  logic                  halted_r, halted_nxt;
  logic                  sign_r, sign_nxt;
  logic [NUM_W-1:0]      acc_r, acc_nxt;
  logic [LABEL_BITS-1:0] lab_r, lab_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  ovf_r, ovf_nxt;

  sym_t sym;
  act_t act;
  pos_t go_pos;
  op_t  op;
  logic start_num, set_sign, num_shift, emit_num;
  logic start_lab, lab_shift, emit_lab;

  logic [LABEL_BITS:0] lab_wide;
  logic [NUM_W-1:0]    num_val;

  always_comb begin
    if (item.char_byte == CH_SPACE) begin
      sym = SYM_S;
    end else if (item.char_byte == CH_TAB) begin
      sym = SYM_T;
    end else if (item.char_byte == CH_LF) begin
      sym = SYM_L;
    end else begin
      sym = SYM_X;
    end
  end

  // decode: what this word does at the current position
  always_comb begin
    act       = ACT_IDLE;
    go_pos    = pos_r;
    op        = OP_ERROR;
    start_num = 1'b0;
    set_sign  = 1'b0;
    num_shift = 1'b0;
    emit_num  = 1'b0;
    start_lab = 1'b0;
    lab_shift = 1'b0;
    emit_lab  = 1'b0;
    if (halted_r) begin
      act = ACT_IDLE;
    end else if (item.end_of_input) begin
      act = (pos_r == POS_START) ? ACT_IDLE : ACT_FAIL;
    end else if (sym == SYM_X) begin
      act = ACT_IDLE;
    end else begin
      case (pos_r)
        POS_START: begin
          act    = ACT_GO;
          go_pos = (sym == SYM_S) ? POS_S : (sym == SYM_T) ? POS_T : POS_L;
        end
        POS_S: begin
          if (sym == SYM_S) begin
            act       = ACT_GO;
            go_pos    = POS_NUM_SIGN;
            start_num = 1'b1;
          end else if (sym == SYM_L) begin
            act    = ACT_GO;
            go_pos = POS_SL;
          end else begin
            act = ACT_FAIL;
          end
        end
        POS_SL: begin
          act = ACT_EMIT;
          op  = (sym == SYM_S) ? OP_DUP : (sym == SYM_T) ? OP_SWAP : OP_DROP;
        end
        POS_T: begin
          act    = ACT_GO;
          go_pos = (sym == SYM_S) ? POS_TS : (sym == SYM_T) ? POS_TT : POS_TL;
        end
        POS_TT: begin
          act = (sym == SYM_L) ? ACT_FAIL : ACT_EMIT;
          op  = (sym == SYM_S) ? OP_STORE : OP_LOAD;
        end
        POS_TS: begin
          act    = (sym == SYM_L) ? ACT_FAIL : ACT_GO;
          go_pos = (sym == SYM_S) ? POS_TSS : POS_TST;
        end
        POS_TSS: begin
          act = ACT_EMIT;
          op  = (sym == SYM_S) ? OP_ADD : (sym == SYM_T) ? OP_SUB : OP_MUL;
        end
        POS_TST: begin
          act = (sym == SYM_L) ? ACT_FAIL : ACT_EMIT;
          op  = (sym == SYM_S) ? OP_DIV : OP_MOD;
        end
        POS_TL: begin
          act    = (sym == SYM_L) ? ACT_FAIL : ACT_GO;
          go_pos = (sym == SYM_S) ? POS_TLS : POS_TLT;
        end
        POS_TLS: begin
          act = (sym == SYM_L) ? ACT_FAIL : ACT_EMIT;
          op  = (sym == SYM_S) ? OP_PUTC : OP_PUTN;
        end
        POS_TLT: begin
          act = (sym == SYM_L) ? ACT_FAIL : ACT_EMIT;
          op  = (sym == SYM_S) ? OP_GETC : OP_GETN;
        end
        POS_L: begin
          act    = ACT_GO;
          go_pos = (sym == SYM_S) ? POS_LS : (sym == SYM_T) ? POS_LT : POS_LL;
        end
        POS_LS: begin
          act       = ACT_GO;
          start_lab = 1'b1;
          go_pos    = (sym == SYM_S) ? POS_LAB_MARK :
                      (sym == SYM_T) ? POS_LAB_CALL : POS_LAB_JUMP;
        end
        POS_LT: begin
          if (sym == SYM_L) begin
            act = ACT_EMIT;
            op  = OP_RET;
          end else begin
            act       = ACT_GO;
            start_lab = 1'b1;
            go_pos    = (sym == SYM_S) ? POS_LAB_JZ : POS_LAB_JNEG;
          end
        end
        POS_LL: begin
          act = (sym == SYM_L) ? ACT_EMIT : ACT_FAIL;
          op  = OP_END;
        end
        POS_NUM_SIGN: begin
          if (sym == SYM_L) begin
            // no sign at all: push zero
            act = ACT_EMIT;
            op  = OP_PUSH;
          end else begin
            act      = ACT_GO;
            go_pos   = POS_NUM_BITS;
            set_sign = 1'b1;
          end
        end
        POS_NUM_BITS: begin
          if (sym == SYM_L) begin
            act      = ACT_EMIT;
            op       = OP_PUSH;
            emit_num = 1'b1;
          end else begin
            num_shift = 1'b1;
          end
        end
        POS_LAB_MARK, POS_LAB_CALL, POS_LAB_JUMP, POS_LAB_JZ, POS_LAB_JNEG: begin
          case (pos_r)
            POS_LAB_MARK: op = OP_LABEL;
            POS_LAB_CALL: op = OP_CALL;
            POS_LAB_JUMP: op = OP_JUMP;
            POS_LAB_JZ:   op = OP_JZ;
            default:      op = OP_JNEG;
          endcase
          if (sym == SYM_L) begin
            act      = ACT_EMIT;
            emit_lab = 1'b1;
          end else begin
            lab_shift = 1'b1;
          end
        end
        default: begin
          act = ACT_FAIL;
        end
      endcase
    end
  end

  assign lab_wide = {lab_r, sym == SYM_T};
  assign num_val  = sign_r ? (NUM_W'(0) - acc_r) : acc_r;

  // next state
  always_comb begin
    pos_nxt    = pos_r;
    halted_nxt = halted_r;
    sign_nxt   = sign_r;
    acc_nxt    = acc_r;
    lab_nxt    = lab_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    if (step) begin
      case (act)
        ACT_GO:   pos_nxt = go_pos;
        ACT_EMIT: pos_nxt = POS_START;
        ACT_FAIL: begin
          pos_nxt    = POS_START;
          halted_nxt = 1'b1;
        end
        default:  pos_nxt = pos_r;
      endcase
      if (start_num) begin
        sign_nxt = 1'b0;
        acc_nxt  = '0;
      end
      if (set_sign) begin
        sign_nxt = (sym == SYM_T);
      end
      if (num_shift) begin
        acc_nxt = {acc_r[NUM_W-2:0], sym == SYM_T};
      end
      if (start_lab) begin
        lab_nxt = '0;
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end
      if (lab_shift) begin
        lab_nxt = lab_wide[LABEL_BITS-1:0];
        // count saturates; further bits mark the overflow and still shift into the label
        if (cnt_r == CNT_W'(LABEL_BITS)) begin
          ovf_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end
  end

  // result; whether the word is actually taken is decided outside
  always_comb begin
    has_result            = (act == ACT_EMIT) || (act == ACT_FAIL);
    result.opcode         = (act == ACT_FAIL) ? OP_ERROR : op;
    result.number         = '0;
    result.label_bits     = '0;
    result.label_length   = '0;
    result.label_overflow = 1'b0;
    if (act == ACT_EMIT) begin
      if (emit_num) begin
        result.number = num_val;
      end
      if (emit_lab) begin
        result.label_bits     = LBL_OUT_W'(lab_r);
        result.label_length   = LEN_OUT_W'(cnt_r);
        result.label_overflow = ovf_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_START;
      halted_r <= 1'b0;
      sign_r   <= 1'b0;
      acc_r    <= '0;
      lab_r    <= '0;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      halted_r <= halted_nxt;
      sign_r   <= sign_nxt;
      acc_r    <= acc_nxt;
      lab_r    <= lab_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

### src/wsd_out_reg.sv
`timescale 1ns / 1ps

module wsd_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  wsd_pkg::res_t result,
  output logic          slot_free,
  wsd_out_if.source     out_ch
);
  import wsd_pkg::*;

  logic valid_r;
  res_t res_r;

  assign slot_free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.opcode         = res_r.opcode;
  assign out_ch.number         = res_r.number;
  assign out_ch.label_bits     = res_r.label_bits;
  assign out_ch.label_length   = res_r.label_length;
  assign out_ch.label_overflow = res_r.label_overflow;

endmodule

### src/whitespace_instruction_decoder.sv
`timescale 1ns / 1ps
// A word that completes an instruction is loaded into the input register on acceptance;
// its result is then decoded combinationally and loaded into the result register.
// Throughput: one word per cycle; the prefix-tree step and the number/label shifts
// are a single pass of logic. A stalled result holds the input only for a word that
// yields a result (a completed instruction or an error).
// Reset (rst_n low, synchronous): parser back at instruction start, not halted,
// both registers empty.
module whitespace_instruction_decoder #(
  parameter int LABEL_BITS = wsd_pkg::LABEL_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  wsd_in_if.sink    in_ch,
  wsd_out_if.source out_ch
);
  import wsd_pkg::*;

  logic  item_valid;
  item_t item;
  logic  has_result;
  res_t  result;
  logic  slot_free;
  logic  advance;

  // a word that yields nothing moves on even while the result register is full
  assign advance = item_valid && (!has_result || slot_free);

  wsd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  wsd_parser #(
    .LABEL_BITS (LABEL_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .item       (item),
    .has_result (has_result),
    .result     (result)
  );

  wsd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && has_result),
    .result    (result),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

endmodule

### src/wsd_checker.sv
`timescale 1ns / 1ps

module wsd_checker #(
  parameter int LABEL_BITS = wsd_pkg::LABEL_BITS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [4:0]         out_opcode,
  input logic signed [31:0] out_number,
  input logic [63:0]        out_label_bits,
  input logic [6:0]         out_label_length,
  input logic               out_label_overflow
);
  import wsd_pkg::*;

  // the error word is the last one until reset
  a_halt_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_opcode == OP_ERROR) |=> !out_valid)
    else $error("result after an error word");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_opcode == OP_ERROR) |->
      (out_number == 0) && (out_label_bits == 0) && (out_label_length == 0) &&
      !out_label_overflow)
    else $error("error word carries data");

  a_number_push_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_opcode != OP_PUSH) |-> (out_number == 0))
    else $error("number on a non-push word");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_label_overflow |-> (out_label_length == 7'(LABEL_BITS)))
    else $error("overflow with label count short of full");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_opcode) && $stable(out_number) &&
      $stable(out_label_bits))
    else $error("stalled result word changed");

endmodule

bind whitespace_instruction_decoder wsd_checker #(
  .LABEL_BITS (LABEL_BITS)
) u_wsd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_opcode         (out_ch.opcode),
  .out_number         (out_ch.number),
  .out_label_bits     (out_ch.label_bits),
  .out_label_length   (out_ch.label_length),
  .out_label_overflow (out_ch.label_overflow)
);
